// File: sv/smv_pkg.sv
// Shared types and constants for the syndrome matrix-vector block.
package smv_pkg;

  // Input opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_MATRIX  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODULUS    = 2'd0;
  localparam logic [1:0] CFG_ROW_LENGTH = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT  = 2'd2;

  localparam logic [15:0] MODULUS_RESET    = 16'd127;
  localparam logic [8:0]  ROW_LENGTH_RESET = 9'd127;
  localparam logic [8:0]  ROW_COUNT_RESET  = 9'd51;
  localparam logic [8:0]  ROW_LIMIT        = 9'd256;

  // Remainder unit: one dividend bit per cycle
  localparam int REM_STEPS = 32;
  localparam int REM_CNT_W = 5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] element_value;
    logic [7:0]  load_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] syndrome_value;
    logic [7:0]  row_index;
    logic        last_row;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_MUL,
    ST_ACC,
    ST_REDUCE,
    ST_EMIT
  } state_t;

endpackage

// File: sv/smv_store.sv
// Error-vector store: one write port, one registered read port.
module smv_store #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [15:0]              wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [15:0]              rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/smv_rem.sv
// Shared bit-serial remainder unit, restoring compare and subtract.
module smv_rem
  import smv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  logic                 active;
  logic [REM_CNT_W-1:0] cnt;
  logic [31:0]          dvd;
  logic [15:0]          dsr;
  logic [15:0]          rem;
  logic [16:0]          trial;
  logic                 fits;
  logic [15:0]          rem_next;

  assign trial     = {rem, dvd[31]};
  assign fits      = trial >= {1'b0, dsr};
  assign rem_next  = fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == REM_CNT_W'(REM_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (active) begin
      rem <= rem_next;
      dvd <= {dvd[30:0], 1'b0};
    end
  end

endmodule

// File: sv/syndrome_matvec_mod_top.sv
// Top level: syndrome s = H*e mod z, one shared bit-serial remainder unit; ready only in idle.
// Load, restart and unused opcodes are taken in idle; a load index past the store first wraps in ST_WRAP.
// Matrix transfer inside a row: accept, multiply, accumulate. Last column of a row: then the
// bit-serial reduction (skipped with modulus zero) and the emit, which waits out an output stall.
// Sync active-high reset clears counters, accumulator, output valid; config reloads defaults.
module syndrome_matvec_mod_top
  import smv_pkg::*;
#(
  parameter int MAX_LENGTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Store address width and a compare width that holds MAX_LENGTH and the 9-bit registers.
  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

  state_t state, state_next;

  // Configuration registers
  logic [15:0] modulus;
  logic [8:0]  row_length;
  logic [8:0]  row_count;

  // Working state
  logic [AW-1:0] col;
  logic [7:0]    row;
  logic [31:0]   acc;
  logic [15:0]   val;
  logic [31:0]   product;
  logic [15:0]   result;
  logic [7:0]    wrap_idx;

  // Store and remainder unit hookup
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [15:0]   rd_data;
  logic          rem_start;
  logic [31:0]   rem_dividend;
  logic [15:0]   rem_divisor;
  logic          rem_done;
  logic [15:0]   rem_value;

  logic          accept;
  logic          need_wrap;
  logic          wrap_fit;
  logic [CW-1:0] len;
  logic [8:0]    rows;
  logic          row_end;
  logic          last;
  logic [31:0]   acc_sum;
  logic          emit_fire;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Index beyond the store wraps modulo MAX_LENGTH by one compare and subtract per cycle.
  assign need_wrap = CW'(in_data.load_index) >= CW'(MAX_LENGTH);
  assign wrap_fit  = CW'(wrap_idx) < CW'(MAX_LENGTH);

  // Clamp row length to 1..MAX_LENGTH and row count to 1..256.
  always_comb begin
    len = CW'(row_length);
    if (row_length == '0) begin
      len = CW'(1);
    end else if (CW'(row_length) > CW'(MAX_LENGTH)) begin
      len = CW'(MAX_LENGTH);
    end
    rows = row_count;
    if (row_count == '0) begin
      rows = 9'd1;
    end else if (row_count > ROW_LIMIT) begin
      rows = ROW_LIMIT;
    end
  end

  assign row_end   = !((CW'(col) + CW'(1)) < len);
  assign last      = (9'(row) + 9'd1) >= rows;
  assign acc_sum   = acc + product;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_LOAD && need_wrap) begin
            state_next = ST_WRAP;
          end else if (in_data.opcode == OP_MATRIX) begin
            state_next = ST_MUL;
          end
        end
      end
      ST_WRAP: begin
        if (wrap_fit) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        if (!row_end) begin
          state_next = ST_IDLE;
        end else if (modulus == '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (rem_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = AW'(in_data.load_index);
    wr_data      = in_data.element_value;
    rem_start    = 1'b0;
    rem_dividend = acc_sum;
    rem_divisor  = modulus;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        wr_en    = in_valid && in_data.opcode == OP_LOAD && !need_wrap;
      end
      ST_WRAP: begin
        wr_en   = wrap_fit;
        wr_addr = AW'(wrap_idx);
        wr_data = val;
      end
      ST_ACC: begin
        rem_start = row_end && modulus != '0;
      end
      ST_MUL, ST_REDUCE, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= MODULUS_RESET;
      row_length <= ROW_LENGTH_RESET;
      row_count  <= ROW_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS:    modulus    <= cfg_data;
        CFG_ROW_LENGTH: row_length <= cfg_data[8:0];
        CFG_ROW_COUNT:  row_count  <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Counters, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept && in_data.opcode == OP_RESTART) begin
        col <= '0;
        row <= '0;
        acc <= '0;
      end
      if (state == ST_ACC) begin
        if (row_end) begin
          col <= '0;
          acc <= '0;
        end else begin
          col <= col + 1'b1;
          acc <= acc_sum;
        end
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
        row       <= last ? 8'd0 : row + 8'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val      <= in_data.element_value;
      wrap_idx <= in_data.load_index;
    end else if (state == ST_WRAP && !wrap_fit) begin
      wrap_idx <= 8'(CW'(wrap_idx) - CW'(MAX_LENGTH));
    end
    if (state == ST_MUL) begin
      product <= 32'(val) * 32'(rd_data);
    end
    if (state == ST_ACC) begin
      result <= acc_sum[15:0];
    end else if (state == ST_REDUCE && rem_done) begin
      result <= rem_value;
    end
    if (emit_fire) begin
      out_data.syndrome_value <= result;
      out_data.row_index      <= row;
      out_data.last_row       <= last;
    end
  end

  smv_store #(
    .DEPTH(MAX_LENGTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (col),
    .rd_data (rd_data)
  );

  smv_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_value)
  );

endmodule

// File: sv/smv_check.sv
// Port-level checker for the syndrome block, bound to the top level.
module smv_check
  import smv_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  logic [15:0] mod_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_seen <= MODULUS_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == CFG_MODULUS) begin
      mod_seen <= cfg_data;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_matrix_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.opcode == OP_MATRIX |=> !in_ready)
    else $error("matrix transfer did not occupy the unit");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mod_seen == '0 || out_data.syndrome_value < mod_seen))
    else $error("syndrome not reduced below modulus");

endmodule

bind syndrome_matvec_mod_top smv_check u_smv_check (.*);

// File: bench/tb_syndrome_matvec_mod_top.sv
// Self-checking bench for the syndrome matrix-vector block: directed table, then random phases.
module tb_syndrome_matvec_mod_top;
  import smv_pkg::*;

  // Store depth of the instance (block default) and codes the package leaves unnamed.
  localparam int unsigned STORE_DEPTH = 256;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  // Longest in-flight work after the last result: a row end with its reduction and emit.
  localparam int DRAIN_CYCLES = 48;
  // Slowest legal run is about 2k transfers, some waiting on reduction and stalls; well above that.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  syndrome_matvec_mod_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the registers, error store, row sum and counters.
  // ---------------------------------------------------------------------------
  logic [15:0]  mod_reg;
  logic [8:0]   len_reg;
  logic [8:0]   rows_reg;
  logic [15:0]  err_mem [STORE_DEPTH];
  logic [31:0]  row_sum;
  int unsigned  col_pos;
  int unsigned  row_pos;
  out_item_t    syndrome_q [$];   // syndromes still owed by the block
  int unsigned  mismatch_cnt;

  // Stimulus bookkeeping: which store entries hold data, current row length and row count.
  bit           err_loaded [STORE_DEPTH];
  int unsigned  phase_len;
  int unsigned  phase_rows;
  bit           in_steady;        // input side in a no-gap stretch

  // Hand-typed expectation for the transfer being driven (directed rows only).
  bit           typed_next;
  out_item_t    typed_want;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    in_item_t    item;
    bit          checked;
    out_item_t   want;
  } plan_row_t;

  plan_row_t plan [$];

  // Zero reads as one, oversize saturates.
  function automatic int unsigned clamp_size(input logic [8:0] v, input int unsigned hi);
    if (v == 9'd0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // One input transfer through the predictor; returns 1 when a syndrome row closes.
  function automatic bit syndrome_step(input in_item_t it, output out_item_t res);
    int unsigned len;
    int unsigned rows;
    bit          last;
    res = '0;
    case (it.opcode)
      OP_LOAD: begin
        err_mem[it.load_index] = it.element_value;
        return 1'b0;
      end
      OP_RESTART: begin
        row_sum = '0;
        col_pos = 0;
        row_pos = 0;
        return 1'b0;
      end
      OP_MATRIX: begin
        len  = clamp_size(len_reg, STORE_DEPTH);
        rows = clamp_size(rows_reg, ROW_LIMIT);
        // 16x16 product fits in 32 bits; the running sum wraps
        row_sum = row_sum + {16'd0, it.element_value} * {16'd0, err_mem[8'(col_pos)]};
        if (col_pos + 1 < len) begin
          col_pos++;
          return 1'b0;
        end
        last = (row_pos + 1 >= rows);
        res.syndrome_value = (mod_reg == 16'd0) ? row_sum[15:0] : 16'(row_sum % mod_reg);
        res.row_index      = row_pos[7:0];
        res.last_row       = last;
        row_sum = '0;
        col_pos = 0;
        row_pos = last ? 0 : row_pos + 1;
        return 1'b1;
      end
      default: return 1'b0;   // unused opcode: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: everything sampled at the rising edge. The output side is checked
  // before this edge's input transfer is predicted, so a result can never be
  // matched against an item accepted in the same cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst) begin
      mod_reg  = MODULUS_RESET;
      len_reg  = ROW_LENGTH_RESET;
      rows_reg = ROW_COUNT_RESET;
      row_sum  = '0;
      col_pos  = 0;
      row_pos  = 0;
      syndrome_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (syndrome_q.size() == 0) begin
          $error("result with no expectation: syndrome_value %0d row_index %0d last_row %0d",
                 got.syndrome_value, got.row_index, got.last_row);
          mismatch_cnt++;
        end else begin
          want = syndrome_q.pop_front();
          if (got.syndrome_value !== want.syndrome_value) begin
            $error("syndrome_value: expected %0d, got %0d", want.syndrome_value,
                   got.syndrome_value);
            mismatch_cnt++;
          end
          if (got.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
            mismatch_cnt++;
          end
          if (got.last_row !== want.last_row) begin
            $error("last_row: expected %0d, got %0d", want.last_row, got.last_row);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODULUS:    mod_reg  = cfg_data;
          CFG_ROW_LENGTH: len_reg  = cfg_data[8:0];
          CFG_ROW_COUNT:  rows_reg = cfg_data[8:0];
          default: ;      // no register behind this index
        endcase
      end
      if (in_valid && in_ready) begin
        if (syndrome_step(in_data, want))
          syndrome_q.push_back(typed_next ? typed_want : want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clock, watchdog, result-side back-pressure.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short stalls, a few long ones, and stretches of steady ready.
  initial begin : out_side
    int unsigned stall;
    int unsigned r;
    bit          steady;
    stall  = 0;
    steady = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) steady = !steady;
      if (stall > 0) begin
        stall--;
      end else if (!steady) begin
        r = $urandom_range(0, 99);
        if (r < 25) stall = $urandom_range(1, 3);
        else if (r < 28) stall = $urandom_range(8, 40);
      end
      out_ready <= (stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Random item shaped around the current row. A column whose store entry was never
  // loaded gets a load first, so the block never reads an unwritten entry.
  function automatic in_item_t next_vector_item();
    in_item_t    it;
    int unsigned r;
    int unsigned mat_w;
    int unsigned restart_w;
    it.opcode    = OP_MATRIX;
    it.load_index = 8'($urandom);
    case ($urandom_range(0, 7))
      0:       it.element_value = 16'h0000;
      1:       it.element_value = 16'hFFFF;
      2:       it.element_value = 16'($urandom_range(0, 15));
      default: it.element_value = 16'($urandom);
    endcase
    if (!err_loaded[8'(col_pos)]) begin
      it.opcode = OP_LOAD;
      if ($urandom_range(0, 3) != 0) it.load_index = 8'(col_pos);
      return it;
    end
    // long rows need nearly uninterrupted matrix streams to ever finish, and long row
    // sets need rare restarts to ever reach the last row
    mat_w     = (phase_len > 16) ? 850 : 700;
    restart_w = (phase_len > 16 || phase_rows > 16) ? 1 : 40;
    r = $urandom_range(0, 999);
    if (r >= 1000 - restart_w) begin
      it.opcode = OP_RESTART;
    end else if (r >= 960 - restart_w) begin
      it.opcode = OP_UNUSED;
    end else if (r >= mat_w) begin
      it.opcode = OP_LOAD;            // reload, often inside the running row
      if (r[0]) it.load_index = 8'($urandom_range(0, phase_len - 1));
    end
    return it;
  endfunction

  // Drive one input transfer, with a random gap in front; data changes at the falling edge.
  task automatic send_input(input bit pick_random, input in_item_t fixed, input bit checked,
                            input out_item_t want);
    in_item_t    it;
    int unsigned gap;
    int unsigned r;
    if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
    gap = 0;
    if (!in_steady) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(6, 20);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    // predictor has settled from the last edge, so the row position is current
    it = pick_random ? next_vector_item() : fixed;
    if (it.opcode == OP_LOAD) err_loaded[it.load_index] = 1'b1;
    typed_next = checked;
    typed_want = want;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Park the input side and wait until the block has nothing left in flight.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (syndrome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: new settings while idle, then a stream of shaped items.
  // Upper data bits on the 9-bit registers are noise the block must drop.
  task automatic run_phase(input logic [15:0] modv, input logic [8:0] lenv,
                           input logic [8:0] rowsv, input int n);
    settle();
    write_reg(CFG_MODULUS, modv);
    write_reg(CFG_ROW_LENGTH, {7'($urandom), lenv});
    write_reg(CFG_ROW_COUNT, {7'($urandom), rowsv});
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 16'($urandom));
    phase_len  = clamp_size(lenv, STORE_DEPTH);
    phase_rows = clamp_size(rowsv, ROW_LIMIT);
    repeat (n) send_input(1'b1, '0, 1'b0, '0);
  endtask

  function automatic void plan_reg(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, item: '0, checked: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_item(input logic [1:0] op, input logic [15:0] val,
                                    input logic [7:0] idx, input bit checked,
                                    input out_item_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, item: {op, val, idx},
            checked: checked, want: want};
    plan.push_back(row);
  endfunction

  initial begin : stimulus
    logic [15:0] modv;
    logic [8:0]  lenv;
    logic [8:0]  rowsv;
    int          p;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatch_cnt = 0;
    in_steady    = 1'b0;
    typed_next   = 1'b0;
    typed_want   = '0;
    phase_len    = 1;
    phase_rows   = 1;
    foreach (err_loaded[i]) err_loaded[i] = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero settings: modulus zero keeps the low half, zero length and count act as one.
    plan_reg(CFG_MODULUS, 16'd0);
    plan_reg(CFG_ROW_LENGTH, 16'd0);
    plan_reg(CFG_ROW_COUNT, 16'd0);
    plan_item(OP_LOAD, 16'hFFFF, 8'd0, 1'b0, '0);
    // 0xFFFF * 0xFFFF = 0xFFFE0001, low half 1; every row is the last
    plan_item(OP_MATRIX, 16'hFFFF, 8'hA5, 1'b1, {16'h0001, 8'd0, 1'b1});
    plan_item(OP_MATRIX, 16'h0000, 8'h00, 1'b1, {16'h0000, 8'd0, 1'b1});
    plan_item(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b0, '0);
    plan_item(OP_LOAD, 16'h1234, 8'hFF, 1'b0, '0);
    plan_item(OP_RESTART, 16'hFFFF, 8'hFF, 1'b0, '0);
    // Max modulus, two columns, three rows; the row sum wraps past 32 bits.
    plan_reg(CFG_MODULUS, 16'hFFFF);
    plan_reg(CFG_ROW_LENGTH, 16'd2);
    plan_reg(CFG_ROW_COUNT, 16'd3);
    plan_item(OP_LOAD, 16'hFFFF, 8'd1, 1'b0, '0);
    plan_item(OP_MATRIX, 16'hFFFF, 8'h00, 1'b0, '0);
    plan_item(OP_MATRIX, 16'hFFFF, 8'h00, 1'b0, '0);
    plan_item(OP_MATRIX, 16'h0001, 8'h00, 1'b0, '0);
    plan_item(OP_RESTART, 16'h0000, 8'h00, 1'b0, '0);   // mid-row restart
    plan_item(OP_MATRIX, 16'h8000, 8'h00, 1'b0, '0);
    plan_item(OP_LOAD, 16'h0000, 8'd1, 1'b0, '0);       // store change inside a row
    plan_item(OP_MATRIX, 16'h7FFF, 8'h00, 1'b0, '0);
    plan_item(OP_MATRIX, 16'hFFFF, 8'h00, 1'b0, '0);
    plan_item(OP_MATRIX, 16'h0001, 8'h00, 1'b0, '0);
    plan_item(OP_MATRIX, 16'h1234, 8'h00, 1'b0, '0);
    plan_item(OP_MATRIX, 16'hFFFF, 8'h00, 1'b0, '0);    // last row, counters wrap
    plan_item(OP_MATRIX, 16'hFFFF, 8'h00, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_input(1'b0, plan[i].item, plan[i].checked, plan[i].want);
      end
    end

    // Extremes first: one-column rows through all 256 row indexes, then the longest rows.
    run_phase(16'd2, 9'd1, 9'd256, 400);
    run_phase(16'hFFFF, 9'd256, 9'd2, 420);
    run_phase(16'($urandom), 9'($urandom_range(257, 511)), 9'd1, 420);

    for (p = 0; p < 5; p++) begin
      case ($urandom_range(0, 5))
        0:       modv = 16'd2;
        1:       modv = 16'hFFFF;
        2:       modv = 16'd0;
        3:       modv = 16'd1;
        4:       modv = 16'($urandom_range(2, 255));
        default: modv = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       lenv = 9'd0;
        1:       lenv = 9'($urandom_range(9, 24));
        default: lenv = 9'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       rowsv = 9'd0;
        1:       rowsv = 9'd256;
        2:       rowsv = 9'($urandom_range(257, 511));
        default: rowsv = 9'($urandom_range(1, 6));
      endcase
      run_phase(modv, lenv, rowsv, 100);
    end

    settle();
    if (mismatch_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: syndrome_matvec_mod_top.f
sv/smv_pkg.sv
sv/smv_store.sv
sv/smv_rem.sv
sv/syndrome_matvec_mod_top.sv
sv/smv_check.sv
bench/tb_syndrome_matvec_mod_top.sv
